@@ src/sbe_pkg.sv @@
// ---------------------------------------------------------------------------
// sbe_pkg
// shared types and character constants of the sixel band encoder
// ---------------------------------------------------------------------------
`default_nettype none
package sbe_pkg;

	localparam int PLANES     = 4;
	localparam int ROWS       = 6;
	localparam int WORD_W     = PLANES * ROWS;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int DEC_W      = 14;

	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [DEC_W-1:0]      dec_t;
	typedef logic [7:0]            byte_t;

	// register indexes
	localparam cfg_idx_t CFG_BAND_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_BAND_HEIGHT = 2'd1;

	// request commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// text characters
	localparam byte_t CHAR_BIAS  = 8'h3f;
	localparam byte_t DIGIT_BIAS = 8'h30;
	localparam byte_t CH_BANG    = 8'h21;
	localparam byte_t CH_HASH    = 8'h23;
	localparam byte_t CH_DOLLAR  = 8'h24;
	localparam byte_t CH_DASH    = 8'h2d;

endpackage
`default_nettype wire

@@ src/sbe_req_if.sv @@
// ---------------------------------------------------------------------------
// sbe_req_if
// request channel: load one pixel or fetch the next text byte
// ---------------------------------------------------------------------------
`default_nettype none
interface sbe_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] pixel;

	modport source (output valid, cmd, pixel, input ready);
	modport sink   (input valid, cmd, pixel, output ready);
endinterface
`default_nettype wire

@@ src/sbe_rsp_if.sv @@
// ---------------------------------------------------------------------------
// sbe_rsp_if
// result channel: one byte of sixel text and the band closing flag
// ---------------------------------------------------------------------------
`default_nettype none
interface sbe_rsp_if;
	import sbe_pkg::*;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  final_byte;

	modport source (output valid, out_byte, final_byte, input ready);
	modport sink   (input valid, out_byte, final_byte, output ready);
endinterface
`default_nettype wire

@@ src/sbe_cfg_if.sv @@
// ---------------------------------------------------------------------------
// sbe_cfg_if
// configuration write channel: register index and write data
// ---------------------------------------------------------------------------
`default_nettype none
interface sbe_cfg_if;
	import sbe_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/sixel_band_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// sixel_band_encoder_unit
// loads one six-row band of 16-color pixels into a column store and then
// hands out the band's sixel text one byte per fetch request
//
// a load request writes the store as it is accepted; the block stays ready for loads
// a fetch request holds ready low until its byte is in the output register:
//   fixed characters come from the first busy step; a byte that starts a run scan
//   first walks the run through the start, first and compare steps, one store
//   read per cycle for each column of the run, and goes straight on to the closing
//   byte when no column is left; a count digit needs one sequencer step per
//   subtraction of the shared digit step and one per leading zero skipped
// a full output register holds the fetch until the receiver takes the byte
// arst_n clears all control state; the column store has no reset or clear
// ---------------------------------------------------------------------------
`default_nettype none
module sixel_band_encoder_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sbe_req_if.sink   pix_req,
	sbe_rsp_if.source byte_rsp,
	sbe_cfg_if.sink   cfg
);
	import sbe_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [12:0] MaxW13 = 13'(MAX_WIDTH);

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	// text phases
	localparam logic [3:0] PH_HASH  = 4'd0;
	localparam logic [3:0] PH_COLOR = 4'd1;
	localparam logic [3:0] PH_RUN   = 4'd2;
	localparam logic [3:0] PH_SHORT = 4'd3;
	localparam logic [3:0] PH_BANG  = 4'd4;
	localparam logic [3:0] PH_D1000 = 4'd5;
	localparam logic [3:0] PH_D100  = 4'd6;
	localparam logic [3:0] PH_D10   = 4'd7;
	localparam logic [3:0] PH_D1    = 4'd8;
	localparam logic [3:0] PH_CHAR  = 4'd9;
	localparam logic [3:0] PH_END   = 4'd10;

	// run scan sub-steps
	localparam logic [1:0] SC_START = 2'd0;
	localparam logic [1:0] SC_FIRST = 2'd1;
	localparam logic [1:0] SC_CMP   = 2'd2;

	// effective geometry, clamped at write time
	logic [COL_W-1:0] width_q;
	logic [2:0]       height_q;

	// sequencer and band state
	logic             state_q, state_d;
	logic [COL_W-1:0] load_col_q, load_col_d;
	logic [2:0]       load_row_q, load_row_d;
	logic             band_ready_q, band_ready_d;
	logic [1:0]       plane_q, plane_d;
	logic [COL_W-1:0] scan_q, scan_d;
	logic [COL_W-1:0] len_q, len_d;
	logic [5:0]       pat_q, pat_d;
	logic [3:0]       phase_q, phase_d;
	logic [1:0]       sub_q, sub_d;
	dec_t             rem_q, rem_d;
	logic [3:0]       digit_q, digit_d;

	// output register
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	// step results
	logic  emit;
	byte_t emit_byte;
	logic  emit_last;
	logic  can_put;
	logic  advance;
	logic  out_load;

	// handshakes
	logic req_fire;
	logic cfg_fire;

	// column store ports
	logic              mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	word_t             mem_wdata;
	word_t             mem_wmask;
	word_t             rd_word;
	logic [5:0]        rd_plane;

	// digit step
	dec_t weight;
	logic dec_ge;
	dec_t dec_diff;

	// config decode
	logic [12:0]      cfg_w13;
	logic [COL_W-1:0] cfg_width;
	logic [2:0]       cfg_height;

	assign pix_req.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign req_fire      = pix_req.valid && pix_req.ready;
	assign cfg_fire      = cfg.valid && cfg.ready;

	assign byte_rsp.valid      = out_valid_q;
	assign byte_rsp.out_byte   = out_byte_q;
	assign byte_rsp.final_byte = out_last_q;

	// zero width means one column, anything past the store means the full store
	assign cfg_w13 = {2'b00, cfg.data};
	always_comb begin
		if (cfg.data == '0) begin
			cfg_width = COL_W'(1);
		end else if (cfg_w13 > MaxW13) begin
			cfg_width = MaxW13[COL_W-1:0];
		end else begin
			cfg_width = cfg_w13[COL_W-1:0];
		end
		if (cfg.data[2:0] == 3'd0) begin
			cfg_height = 3'd1;
		end else if (cfg.data[2:0] > 3'(ROWS)) begin
			cfg_height = 3'(ROWS);
		end else begin
			cfg_height = cfg.data[2:0];
		end
	end

	// load data: row zero rewrites the whole column, later rows set their own bits
	always_comb begin
		mem_wdata = '0;
		mem_wmask = '0;
		for (int p = 0; p < PLANES; p++) begin
			mem_wdata[p*ROWS + int'(load_row_q)] = pix_req.pixel[p];
			mem_wmask[p*ROWS + int'(load_row_q)] = 1'b1;
		end
		if (load_row_q == 3'd0) begin
			mem_wmask = '1;
		end
	end

	assign mem_we = req_fire && (pix_req.cmd == CMD_LOAD) && !band_ready_q;

	sbe_col_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (load_col_q[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.wmask (mem_wmask),
		.raddr (mem_raddr),
		.rdata (rd_word)
	);

	// six pattern bits of the plane being drained
	always_comb begin
		case (plane_q)
			2'd0:    rd_plane = rd_word[5:0];
			2'd1:    rd_plane = rd_word[11:6];
			2'd2:    rd_plane = rd_word[17:12];
			default: rd_plane = rd_word[23:18];
		endcase
	end

	// decimal weight of the digit being worked on
	always_comb begin
		case (phase_q)
			PH_D1000: weight = 14'd1000;
			PH_D100:  weight = 14'd100;
			PH_D10:   weight = 14'd10;
			default:  weight = 14'd1;
		endcase
	end

	sbe_dec_step u_dec (
		.rem    (rem_q),
		.weight (weight),
		.ge     (dec_ge),
		.diff   (dec_diff)
	);

	assign can_put = !out_valid_q || byte_rsp.ready;

	// one sequencer step per cycle, unless a byte waits for room in the output register
	always_comb begin
		state_d      = state_q;
		load_col_d   = load_col_q;
		load_row_d   = load_row_q;
		band_ready_d = band_ready_q;
		plane_d      = plane_q;
		scan_d       = scan_q;
		len_d        = len_q;
		pat_d        = pat_q;
		phase_d      = phase_q;
		sub_d        = sub_q;
		rem_d        = rem_q;
		digit_d      = digit_q;
		emit         = 1'b0;
		emit_byte    = CH_HASH;
		emit_last    = 1'b0;
		// the start of a run reads its first column, later steps read one ahead
		if (sub_q == SC_START) begin
			mem_raddr = scan_q[ADDR_W-1:0];
		end else begin
			mem_raddr = ADDR_W'(scan_q + COL_W'(1));
		end

		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (pix_req.cmd == CMD_LOAD) begin
						if (!band_ready_q) begin
							load_col_d = load_col_q + COL_W'(1);
							if (load_col_d >= width_q) begin
								load_col_d = '0;
								load_row_d = load_row_q + 3'd1;
								if (load_row_d >= height_q) begin
									// band complete, start draining from plane zero
									load_row_d   = '0;
									band_ready_d = 1'b1;
									plane_d      = '0;
									scan_d       = '0;
									len_d        = COL_W'(1);
									pat_d        = '0;
									phase_d      = PH_HASH;
									sub_d        = SC_START;
								end
							end
						end
					end else if (band_ready_q) begin
						state_d = ST_BUSY;
					end
				end
			end
			default: begin
				case (phase_q)
					PH_HASH: begin
						emit      = 1'b1;
						emit_byte = CH_HASH;
						phase_d   = PH_COLOR;
					end
					PH_COLOR: begin
						emit      = 1'b1;
						emit_byte = DIGIT_BIAS + (8'd1 << plane_q);
						scan_d    = '0;
						sub_d     = SC_START;
						phase_d   = PH_RUN;
					end
					PH_RUN: begin
						case (sub_q)
							SC_START: begin
								if (scan_q >= width_q) begin
									phase_d = PH_END;
								end else begin
									sub_d = SC_FIRST;
								end
							end
							SC_FIRST: begin
								pat_d  = rd_plane;
								len_d  = COL_W'(1);
								scan_d = scan_q + COL_W'(1);
								sub_d  = SC_CMP;
							end
							default: begin
								if (scan_q < width_q && rd_plane == pat_q) begin
									len_d  = len_q + COL_W'(1);
									scan_d = scan_q + COL_W'(1);
								end else begin
									sub_d = SC_START;
									// a blank run that reaches the last column is dropped
									if (scan_q >= width_q && pat_q == '0) begin
										phase_d = PH_END;
									end else if (len_q <= COL_W'(3)) begin
										phase_d = PH_SHORT;
									end else begin
										phase_d = PH_BANG;
									end
								end
							end
						endcase
					end
					PH_SHORT: begin
						emit      = 1'b1;
						emit_byte = {2'b00, pat_q} + CHAR_BIAS;
						len_d     = len_q - COL_W'(1);
						if (len_q == COL_W'(1)) begin
							phase_d = PH_RUN;
						end
					end
					PH_BANG: begin
						emit      = 1'b1;
						emit_byte = CH_BANG;
						rem_d     = DEC_W'(len_q);
						digit_d   = '0;
						phase_d   = PH_D1000;
					end
					PH_D1000, PH_D100, PH_D10: begin
						if (dec_ge) begin
							rem_d   = dec_diff;
							digit_d = digit_q + 4'd1;
						end else begin
							digit_d = '0;
							case (phase_q)
								PH_D1000: phase_d = PH_D100;
								PH_D100:  phase_d = PH_D10;
								default:  phase_d = PH_D1;
							endcase
							// no leading zeros
							if (DEC_W'(len_q) >= weight) begin
								emit      = 1'b1;
								emit_byte = DIGIT_BIAS + {4'd0, digit_q};
							end
						end
					end
					PH_D1: begin
						emit      = 1'b1;
						emit_byte = DIGIT_BIAS + {4'd0, rem_q[3:0]};
						phase_d   = PH_CHAR;
					end
					PH_CHAR: begin
						emit      = 1'b1;
						emit_byte = {2'b00, pat_q} + CHAR_BIAS;
						phase_d   = PH_RUN;
					end
					default: begin
						emit = 1'b1;
						if (plane_q == 2'(PLANES - 1)) begin
							// closing dash, band done and loading starts over
							emit_byte    = CH_DASH;
							emit_last    = 1'b1;
							load_col_d   = '0;
							load_row_d   = '0;
							band_ready_d = 1'b0;
							plane_d      = '0;
							scan_d       = '0;
							len_d        = COL_W'(1);
							pat_d        = '0;
							sub_d        = SC_START;
							phase_d      = PH_HASH;
						end else begin
							emit_byte = CH_DOLLAR;
							plane_d   = plane_q + 2'd1;
							phase_d   = PH_HASH;
						end
					end
				endcase
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// a step that yields a byte waits for room in the output register
	assign advance  = (state_q == ST_IDLE && req_fire) ||
	                  (state_q == ST_BUSY && (!emit || can_put));
	assign out_load = (state_q == ST_BUSY) && emit && can_put;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= COL_W'(1);
			height_q     <= 3'(ROWS);
			state_q      <= ST_IDLE;
			load_col_q   <= '0;
			load_row_q   <= '0;
			band_ready_q <= 1'b0;
			plane_q      <= '0;
			scan_q       <= '0;
			len_q        <= COL_W'(1);
			pat_q        <= '0;
			phase_q      <= PH_HASH;
			sub_q        <= SC_START;
			rem_q        <= '0;
			digit_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_fire &&
			    (cfg.index == CFG_BAND_WIDTH || cfg.index == CFG_BAND_HEIGHT)) begin
				// any known register write restarts the band
				if (cfg.index == CFG_BAND_WIDTH) begin
					width_q <= cfg_width;
				end else begin
					height_q <= cfg_height;
				end
				state_q      <= ST_IDLE;
				load_col_q   <= '0;
				load_row_q   <= '0;
				band_ready_q <= 1'b0;
				plane_q      <= '0;
				scan_q       <= '0;
				len_q        <= COL_W'(1);
				pat_q        <= '0;
				phase_q      <= PH_HASH;
				sub_q        <= SC_START;
			end else if (advance) begin
				state_q      <= state_d;
				load_col_q   <= load_col_d;
				load_row_q   <= load_row_d;
				band_ready_q <= band_ready_d;
				plane_q      <= plane_d;
				scan_q       <= scan_d;
				len_q        <= len_d;
				pat_q        <= pat_d;
				phase_q      <= phase_d;
				sub_q        <= sub_d;
				rem_q        <= rem_d;
				digit_q      <= digit_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (byte_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	// drain work only runs on a complete band
	a_busy_needs_band: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> band_ready_q)
		else $error("fetch sequencer busy without a loaded band");

	// the closing flag only rides on a dash
	a_final_is_dash: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_byte_q == CH_DASH))
		else $error("band closing flag on a byte other than dash");

	// closing the band hands the store back to loading
	a_close_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_last && !cfg_fire) |=> (!band_ready_q && load_col_q == '0))
		else $error("band not restarted after closing byte");

	// load position stays inside the band geometry
	a_load_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		(load_row_q < height_q) && (load_col_q < width_q))
		else $error("load position outside the band");

	// the run scan never walks past the band width
	a_scan_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> (scan_q <= width_q))
		else $error("run scan beyond band width");

endmodule
`default_nettype wire

@@ src/sbe_col_store.sv @@
// ---------------------------------------------------------------------------
// sbe_col_store
// column store, one word of four planes by six rows per column,
// bit-masked write port and registered read port
// ---------------------------------------------------------------------------
`default_nettype none
module sbe_col_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [ADDR_W-1:0]   waddr,
	input  wire sbe_pkg::word_t      wdata,
	input  wire sbe_pkg::word_t      wmask,
	input  wire logic [ADDR_W-1:0]   raddr,
	output sbe_pkg::word_t           rdata
);
	import sbe_pkg::*;

	word_t mem_q [DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < WORD_W; b++) begin
				if (wmask[b]) begin
					mem_q[waddr][b] <= wdata[b];
				end
			end
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/sbe_dec_step.sv @@
// ---------------------------------------------------------------------------
// sbe_dec_step
// shared compare and subtract step used to peel off decimal digits
// ---------------------------------------------------------------------------
`default_nettype none
module sbe_dec_step (
	input  wire sbe_pkg::dec_t rem,
	input  wire sbe_pkg::dec_t weight,
	output logic               ge,
	output sbe_pkg::dec_t      diff
);
	import sbe_pkg::*;

	assign ge   = (rem >= weight);
	assign diff = rem - weight;

endmodule
`default_nettype wire
